FILE: rtl/bads_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_pkg
// Shared widths, register indexes and interface structs of the block
// average downsampler.
// ----------------------------------------------------------------------------
package bads_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int POS_W        = 12;
  localparam int WIDTH_W      = 13;
  localparam int LOG_W        = 2;
  localparam int RUN_W        = 19;
  localparam int SUM_W        = 22;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int WIDTH_LIMIT  = 4096;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd1024;
  localparam logic [LOG_W-1:0]   BLOCK_LOG2_RST  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2  = 2'd1;

  localparam int SAMPLE_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((33'h1 << SAMPLE_KEEP) - 33'h1);

  typedef struct packed {
    logic [WIDTH_W-1:0] eff_w;
    logic [LOG_W-1:0]   lg;
    logic [WIDTH_W-1:0] nb;
    logic [WIDTH_W-1:0] used;
  } geom_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic             emit;
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [RUN_W-1:0] run;
    logic [LOG_W-1:0] lg;
  } acc_req_t;

endpackage

FILE: rtl/bads_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_cfg
// Configuration registers and the frame geometry derived from them.
// ----------------------------------------------------------------------------
module bads_cfg #(
  parameter int MAX_WIDTH = bads_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bads_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bads_pkg::WIDTH_W-1:0]   cfg_wdata,
  output logic                           restart,
  output bads_pkg::geom_t                geom
);
  import bads_pkg::*;

  localparam int WMAX = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
  localparam logic [WIDTH_W-1:0] WMAX_V = WIDTH_W'(WMAX);

  logic [WIDTH_W-1:0] image_width_r, image_width_nxt;
  logic [LOG_W-1:0]   block_log2_r, block_log2_nxt;
  logic               wr_en;
  logic [WIDTH_W-1:0] w;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_comb begin
    image_width_nxt = image_width_r;
    block_log2_nxt  = block_log2_r;
    restart         = 1'b0;
    if (wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width_nxt = cfg_wdata;
          restart         = 1'b1;
        end
        REG_BLOCK_LOG2: begin
          block_log2_nxt = cfg_wdata[LOG_W-1:0];
          restart        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      block_log2_r  <= BLOCK_LOG2_RST;
    end else begin
      image_width_r <= image_width_nxt;
      block_log2_r  <= block_log2_nxt;
    end
  end

  always_comb begin
    w = image_width_r;
    if (w == '0) w = WIDTH_W'(1);
    if (w > WMAX_V) w = WMAX_V;
  end

  assign geom.eff_w = w;
  assign geom.lg    = block_log2_r;
  assign geom.nb    = w >> block_log2_r;
  assign geom.used  = (w >> block_log2_r) << block_log2_r;

endmodule

FILE: rtl/bads_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_scan
// Raster position tracking and horizontal run sums; issues one column
// store request per finished block run.
// ----------------------------------------------------------------------------
module bads_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          accept,
  input  logic [bads_pkg::SAMPLE_W-1:0] sample,
  input  bads_pkg::geom_t               geom,
  output bads_pkg::acc_req_t            req
);
  import bads_pkg::*;

  logic [POS_W-1:0]   in_col_r, in_col_nxt;
  logic [POS_W-1:0]   in_row_r, in_row_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [SAMPLE_W-1:0] s;
  logic [POS_W-1:0]   lmask, sx, sy, bc, br;
  logic [WIDTH_W-1:0] x1, y1;
  logic               in_range, last_sx;

  assign s      = sample & SAMPLE_MASK;
  assign lmask  = ~({POS_W{1'b1}} << geom.lg);
  assign sx     = in_col_r & lmask;
  assign sy     = in_row_r & lmask;
  assign bc     = in_col_r >> geom.lg;
  assign br     = in_row_r >> geom.lg;
  assign x1     = {1'b0, in_col_r} + WIDTH_W'(1);
  assign y1     = {1'b0, in_row_r} + WIDTH_W'(1);
  assign in_range = ({1'b0, in_col_r} < geom.used) && ({1'b0, in_row_r} < geom.used);
  assign last_sx  = (sx == lmask);

  always_comb begin
    run_nxt = run_r;
    if (in_range) begin
      if (sx == '0) run_nxt = RUN_W'(s);
      else          run_nxt = run_r + RUN_W'(s);
    end
  end

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (x1 >= geom.eff_w) begin
      in_col_nxt = '0;
      in_row_nxt = (y1 >= geom.eff_w) ? '0 : y1[POS_W-1:0];
    end else begin
      in_col_nxt = x1[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      run_r    <= '0;
    end else if (restart) begin
      in_col_r <= '0;
      in_row_r <= '0;
      run_r    <= '0;
    end else if (accept) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      run_r    <= run_nxt;
    end
  end

  always_comb begin
    req.wr        = in_range && last_sx;
    req.rd        = in_range && last_sx && (sy != '0);
    req.emit      = in_range && last_sx && (sy == lmask);
    req.frame_end = ({1'b0, bc} == geom.nb - WIDTH_W'(1)) &&
                    ({1'b0, br} == geom.nb - WIDTH_W'(1));
    req.col       = bc;
    req.row       = br;
    req.run       = run_nxt;
    req.lg        = geom.lg;
  end

endmodule

FILE: rtl/bads_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_accum
// Per-block-column sum store with read-modify-write, block mean and the
// output register.
// ----------------------------------------------------------------------------
module bads_accum #(
  parameter int MAX_WIDTH = bads_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  bads_pkg::acc_req_t            req,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bads_pkg::SAMPLE_W-1:0] out_average,
  output logic [bads_pkg::POS_W-1:0]    out_col,
  output logic [bads_pkg::POS_W-1:0]    out_row,
  output logic                          out_frame_end
);
  import bads_pkg::*;

  localparam int DEPTH  = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0]  mem [DEPTH];
  logic [SUM_W-1:0]  rd_data_r;
  acc_req_t          s1_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_go, mem_re, mem_we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  shifted;
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] avg_r;
  logic [POS_W-1:0]  col_r, row_r;
  logic              fe_r;

  assign s1_go  = !s1_r.emit || !out_valid_r || !out_stall;
  assign ready  = !s1_valid_r || s1_go;
  assign mem_re = accept && req.rd;
  assign mem_we = s1_valid_r && s1_go;
  assign raddr  = ADDR_W'(req.col);
  assign waddr  = ADDR_W'(s1_r.col);
  assign total  = s1_r.rd ? (rd_data_r + SUM_W'(s1_r.run)) : SUM_W'(s1_r.run);
  assign shifted = total >> {s1_r.lg, 1'b0};

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= total;
    if (mem_re) rd_data_r <= mem[raddr];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)     s1_valid_nxt = req.wr;
    else if (s1_go) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) s1_r <= req;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_valid_r && s1_go && s1_r.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go && s1_r.emit) begin
      avg_r <= shifted[SAMPLE_W-1:0];
      col_r <= s1_r.col;
      row_r <= s1_r.row;
      fe_r  <= s1_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_average   = avg_r;
  assign out_col       = col_r;
  assign out_row       = row_r;
  assign out_frame_end = fe_r;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we && (raddr == waddr)))
    else $error("column store read and write hit the same entry");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stalled accumulate stage changed");

  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.emit && out_valid_r && out_stall) |-> !ready)
    else $error("input taken while result path blocked");

  a_emit_implies_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.emit) |-> s1_r.wr)
    else $error("result without column store update");

endmodule

FILE: rtl/block_average_downsampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downsampler_top
// Average pooling of a square raster field by a factor of 1, 2, 4 or 8.
// ----------------------------------------------------------------------------
// Result path: a block's last sample goes to the accumulate stage, then the output register.
// Throughput: 1 sample per clock while in_stall is low; the column store does one read and one write
//   per cycle (read at accept, write back from the accumulate stage register).
// Reset: position and run sum clear, image_width 1024, block_log2 2; the
//   column store is not cleared, the first row of each block row overwrites it.
// ----------------------------------------------------------------------------
module block_average_downsampler_top #(
  parameter int MAX_WIDTH = bads_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bads_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bads_pkg::SAMPLE_W-1:0]  out_average,
  output logic [bads_pkg::POS_W-1:0]     out_col,
  output logic [bads_pkg::POS_W-1:0]     out_row,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bads_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bads_pkg::WIDTH_W-1:0]   cfg_wdata
);
  import bads_pkg::*;

  geom_t    geom;
  acc_req_t req;
  logic     restart, ready, accept;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  bads_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .restart   (restart),
    .geom      (geom)
  );

  bads_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .accept  (accept),
    .sample  (in_sample),
    .geom    (geom),
    .req     (req)
  );

  bads_accum #(.MAX_WIDTH(MAX_WIDTH)) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .req           (req),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_average   (out_average),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_frame_end (out_frame_end)
  );

endmodule
